// ===== rtl/tga_rle_pixel_decoder_core_defines.svh =====
// Assertion macros shared by the decoder RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TGARLE_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TGARLE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/tgarle_pkg.sv =====
package tgarle_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [1:0] REG_RLE_MODE        = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd3;

    localparam int CFG_DATA_W = 16;

    // Decoded configuration handed to the byte stepper.
    typedef struct packed {
        logic [1:0]  bpp_m1;      // effective bytes per pixel minus one
        logic        rle;         // stream is run-length packets
        logic [31:0] total;       // pixels in one image
    } cfg_t;

    // One decoded result.
    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        last_of_image;
    } result_t;

endpackage

// ===== rtl/tgarle_cfg.sv =====
module tgarle_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [1:0]                           cfg_index,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tgarle_pkg::cfg_t                     cfg
);
    import tgarle_pkg::*;

    logic [2:0]  bpp_reg;
    logic        rle_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] total_reg;
    logic [31:0] total_next;
    logic [15:0] eff_width;
    logic [15:0] eff_height;
    logic [1:0]  bpp_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= 3'd4;
            rle_reg    <= 1'b1;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BYTES_PER_PIXEL: bpp_reg    <= cfg_data[2:0];
                REG_RLE_MODE:        rle_reg    <= cfg_data[0];
                REG_IMAGE_WIDTH:     width_reg  <= cfg_data[15:0];
                REG_IMAGE_HEIGHT:    height_reg <= cfg_data[15:0];
                default:             bpp_reg    <= bpp_reg;
            endcase
        end
    end

    // A zero dimension counts as one.
    assign eff_width  = (width_reg  == 16'd0) ? 16'd1 : width_reg;
    assign eff_height = (height_reg == 16'd0) ? 16'd1 : height_reg;
    assign total_next = 32'(eff_width) * 32'(eff_height);

    // The image size is registered behind the dimension registers; the first byte
    // after a write also passes the byte register before it reaches the stepper.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= 32'd1;
        else
            total_reg <= total_next;
    end

    // A depth of zero acts as one byte, depths above four act as four.
    always_comb
    begin
        case (bpp_reg)
            3'd0, 3'd1: bpp_m1 = 2'd0;
            3'd2:       bpp_m1 = 2'd1;
            3'd3:       bpp_m1 = 2'd2;
            default:    bpp_m1 = 2'd3;
        endcase
    end

    assign cfg.bpp_m1 = bpp_m1;
    assign cfg.rle    = rle_reg;
    assign cfg.total  = total_reg;

endmodule

// ===== rtl/tgarle_step.sv =====
module tgarle_step
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   restart,
    input  logic                   fire,
    input  logic [7:0]             data_in,
    input  tgarle_pkg::cfg_t       cfg,
    output logic                   has_result,
    output tgarle_pkg::result_t    result
);
    import tgarle_pkg::*;

    logic        awaiting_reg,  awaiting_next;
    logic        is_run_reg,    is_run_next;
    logic [7:0]  pkt_left_reg,  pkt_left_next;
    logic [1:0]  pos_reg,       pos_next;
    logic [23:0] partial_reg,   partial_next;
    // Zero means a fresh image: the full pixel count applies.
    logic [31:0] img_left_reg,  img_left_next;

    logic [31:0] img_left;
    logic [7:0]  count;
    logic [31:0] pix_raw;
    logic [31:0] pix;
    logic [7:0]  repeat_raw;
    logic [7:0]  repeat_val;
    logic [31:0] img_after;

    assign img_left = (img_left_reg == 32'd0) ? cfg.total : img_left_reg;

    always_comb
    begin
        awaiting_next = awaiting_reg;
        is_run_next   = is_run_reg;
        pkt_left_next = pkt_left_reg;
        pos_next      = pos_reg;
        partial_next  = partial_reg;
        img_left_next = img_left_reg;
        has_result    = 1'b0;
        count         = {1'b0, data_in[6:0]} + 8'd1;
        pix_raw       = {8'd0, partial_reg} | (32'(data_in) << {pos_reg, 3'b000});
        pix           = pix_raw;
        repeat_raw    = 8'd1;
        repeat_val    = 8'd1;
        img_after     = img_left;

        if (cfg.rle && awaiting_reg)
        begin
            // Packet header: the count never runs past the end of the image.
            if (32'(count) > img_left)
                count = img_left[7:0];
            is_run_next   = data_in[7];
            pkt_left_next = count;
            awaiting_next = 1'b0;
            pos_next      = 2'd0;
            partial_next  = 24'd0;
        end
        else if (pos_reg < cfg.bpp_m1)
        begin
            pos_next     = pos_reg + 2'd1;
            partial_next = pix_raw[23:0];
        end
        else
        begin
            // Three- and four-byte pixels arrive blue first.
            if (cfg.bpp_m1 >= 2'd2)
                pix = {pix_raw[31:24], pix_raw[7:0], pix_raw[15:8], pix_raw[23:16]};
            pos_next     = 2'd0;
            partial_next = 24'd0;
            if (cfg.rle && is_run_reg)
            begin
                repeat_raw    = (pkt_left_reg == 8'd0) ? 8'd1 : pkt_left_reg;
                pkt_left_next = 8'd0;
            end
            else
            begin
                repeat_raw = 8'd1;
                if (pkt_left_reg != 8'd0)
                    pkt_left_next = pkt_left_reg - 8'd1;
            end
            repeat_val = (32'(repeat_raw) > img_left) ? img_left[7:0] : repeat_raw;
            img_after  = img_left - 32'(repeat_val);
            if (cfg.rle && pkt_left_next == 8'd0)
                awaiting_next = 1'b1;
            has_result    = 1'b1;
            img_left_next = img_after;
            if (img_after == 32'd0)
            begin
                awaiting_next = 1'b1;
                is_run_next   = 1'b0;
                pkt_left_next = 8'd0;
            end
        end
    end

    assign result.pixel_value   = pix;
    assign result.repeat_count  = repeat_val;
    assign result.last_of_image = (img_after == 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            is_run_reg   <= 1'b0;
            pkt_left_reg <= 8'd0;
            pos_reg      <= 2'd0;
            partial_reg  <= 24'd0;
            img_left_reg <= 32'd0;
        end
        else if (restart)
        begin
            awaiting_reg <= 1'b1;
            is_run_reg   <= 1'b0;
            pkt_left_reg <= 8'd0;
            pos_reg      <= 2'd0;
            partial_reg  <= 24'd0;
            img_left_reg <= 32'd0;
        end
        else if (fire)
        begin
            awaiting_reg <= awaiting_next;
            is_run_reg   <= is_run_next;
            pkt_left_reg <= pkt_left_next;
            pos_reg      <= pos_next;
            partial_reg  <= partial_next;
            img_left_reg <= img_left_next;
        end
    end

endmodule

// ===== rtl/tga_rle_pixel_decoder_core.sv =====
// Channel   Direction  Handshake                  Payload
// byte      in         byte_valid / byte_stall    data_byte
// pixel     out        pixel_valid / pixel_stall  pixel_value, repeat_count, last_of_image
// cfg       in         cfg_write                  cfg_index, cfg_data
//
// One byte is taken per cycle while byte_stall is low. An accepted byte sits in
// the byte register while the decode logic works on it, and its pixel is
// written to the pixel register when the decoder advances.
// The decode step carries its packet and pixel state from one byte to the next
// combinationally, which is what sets the one-byte-per-cycle rate.
// Reset is asynchronous and active low and leaves the block at the start of an
// image with four bytes per pixel, RLE mode and a one by one image.
// A stall on the pixel side holds the byte register once the pixel register is
// full and not being taken; byte_stall follows pixel_stall within that cycle.
// Any register write restarts decoding at the start of a new image.
`include "tga_rle_pixel_decoder_core_defines.svh"

module tga_rle_pixel_decoder_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [1:0]                           cfg_index,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 byte_valid,
    output logic                                 byte_stall,
    input  logic [7:0]                           data_byte,
    output logic                                 pixel_valid,
    input  logic                                 pixel_stall,
    output logic [31:0]                          pixel_value,
    output logic [7:0]                           repeat_count,
    output logic                                 last_of_image
);
    import tgarle_pkg::*;

    cfg_t        cfg;
    result_t     step_result;
    logic        step_has_result;

    // Byte register: holds one accepted request until the decoder takes it.
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;

    // Pixel register: holds one finished result until downstream takes it.
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;

    logic        advance;

    tgarle_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The decoder may step whenever the pixel register is empty or is being
    // emptied in this cycle, so a result being taken does not block the next byte.
    assign advance    = in_valid_reg && (!out_valid_reg || !pixel_stall);
    assign byte_stall = in_valid_reg && !advance;

    tgarle_step u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_write),
        .fire       (advance),
        .data_in    (in_byte_reg),
        .cfg        (cfg),
        .has_result (step_has_result),
        .result     (step_result)
    );

    assign in_valid_next  = byte_stall ? in_valid_reg : byte_valid;
    assign out_valid_next = (advance && step_has_result) ||
                            (out_valid_reg && pixel_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            in_byte_reg <= data_byte;
        if (advance && step_has_result)
            out_reg <= step_result;
    end

    assign pixel_valid   = out_valid_reg;
    assign pixel_value   = out_reg.pixel_value;
    assign repeat_count  = out_reg.repeat_count;
    assign last_of_image = out_reg.last_of_image;

    // The input side only waits while a byte is actually held.
    `TGARLE_ASSERT_NOW(a_stall_only_when_held, byte_stall, in_valid_reg,
        "byte_stall raised with an empty byte register")
    // A decoded pixel always lands in the pixel register.
    `TGARLE_ASSERT_NEXT(a_result_lands, advance && step_has_result, out_valid_reg,
        "decoded pixel did not reach the pixel register")
    // A repeat count is never zero.
    `TGARLE_ASSERT_NOW(a_repeat_nonzero, pixel_valid, repeat_count != 8'd0,
        "pixel delivered with a zero repeat count")
    // Repeats above one only come from run packets.
    `TGARLE_ASSERT_NOW(a_repeat_needs_rle, pixel_valid && repeat_count != 8'd1, cfg.rle,
        "repeat count above one outside RLE mode")

endmodule

// ===== dv/tga_rle_pixel_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_core_tb;

    import tgarle_pkg::*;

    // The decoder holds a byte in its byte register before its pixel shows up. The
    // drain margin covers a header or partial-pixel byte still in flight when the
    // last expected pixel leaves.
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES    = 630;
    // Byte count after which send_image starts no further packet of a random
    // image. This keeps large images affordable.
    localparam int IMAGE_BYTE_CAP = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    logic [7:0]            data_byte = '0;
    logic                  pixel_valid;
    logic                  pixel_stall = 1'b0;
    logic [31:0]           pixel_value;
    logic [7:0]            repeat_count;
    logic                  last_of_image;

    tga_rle_pixel_decoder_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel_value   (pixel_value),
        .repeat_count  (repeat_count),
        .last_of_image (last_of_image)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Percentages of cycles in which the byte source holds back a request and
    // the pixel sink stalls. The main sequence changes them between phases.
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;

    // Run statistics and the failure count.
    int unsigned bytes_sent    = 0;
    int unsigned pixels_seen   = 0;
    int unsigned reg_writes    = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;

    // Pixels that the decoder still owes, oldest first.
    result_t expected_pixels[$];

    // Shadow copy of the configuration registers.
    logic [2:0]  cfg_bpp;
    logic        cfg_rle;
    logic [15:0] cfg_width;
    logic [15:0] cfg_height;

    // Shadow copy of the decoder's packet and pixel state.
    logic        hdr_pending;
    logic        run_packet;
    logic [7:0]  pkt_left;
    logic [1:0]  byte_idx;
    logic [23:0] partial_pixel;
    logic [31:0] image_left;

    // Depth codes of 0 act as one byte and codes above 4 act as four.
    function automatic int unsigned eff_bpp();
        if (cfg_bpp == 3'd0)
            return 1;
        if (cfg_bpp > 3'd4)
            return 4;
        return cfg_bpp;
    endfunction

    // A zero dimension counts as one pixel.
    function automatic logic [31:0] image_size();
        logic [31:0] w;
        logic [31:0] h;
        w = (cfg_width == 16'd0) ? 32'd1 : 32'(cfg_width);
        h = (cfg_height == 16'd0) ? 32'd1 : 32'(cfg_height);
        return w * h;
    endfunction

    function automatic void begin_image();
        hdr_pending   = 1'b1;
        run_packet    = 1'b0;
        pkt_left      = '0;
        byte_idx      = '0;
        partial_pixel = '0;
        image_left    = image_size();
    endfunction

    function automatic void apply_register(input logic [1:0] index,
                                           input logic [CFG_DATA_W-1:0] value);
        case (index)
            REG_BYTES_PER_PIXEL: cfg_bpp    = value[2:0];
            REG_RLE_MODE:        cfg_rle    = value[0];
            REG_IMAGE_WIDTH:     cfg_width  = value[15:0];
            REG_IMAGE_HEIGHT:    cfg_height = value[15:0];
            default: ;
        endcase
        // Every write starts a fresh image, dropping any partial pixel or packet.
        begin_image();
    endfunction

    // Advances the shadow decoder by one accepted byte. Returns 1 and the
    // decoded pixel when the byte completes one.
    function automatic bit decode_byte(input logic [7:0] b, output result_t pix);
        int unsigned bpp;
        logic [31:0] count;
        logic [31:0] word;
        logic [31:0] reps;
        bpp = eff_bpp();
        pix = '0;

        // A packet header only sets up the packet. Counts that reach past the
        // end of the image are trimmed to what is left of it.
        if (cfg_rle && hdr_pending)
        begin
            count = 32'(b[6:0]) + 32'd1;
            if (count > image_left)
                count = image_left;
            run_packet    = b[7];
            pkt_left      = count[7:0];
            hdr_pending   = 1'b0;
            byte_idx      = '0;
            partial_pixel = '0;
            return 1'b0;
        end

        // Bytes before the last one of a pixel are only collected.
        if (int'(byte_idx) + 1 < bpp)
        begin
            partial_pixel = partial_pixel | (24'(b) << (8 * byte_idx));
            byte_idx      = byte_idx + 2'd1;
            return 1'b0;
        end

        word = 32'(partial_pixel) | (32'(b) << (8 * (bpp - 1)));
        if (bpp < 4)
            word = word & ((32'd1 << (8 * bpp)) - 32'd1);
        // Stored BGR(A) is handed out as RGB(A).
        if (bpp >= 3)
            word = {word[31:24], word[7:0], word[15:8], word[23:16]};
        byte_idx      = '0;
        partial_pixel = '0;

        if (cfg_rle && run_packet)
        begin
            reps     = (pkt_left != 8'd0) ? 32'(pkt_left) : 32'd1;
            pkt_left = '0;
        end
        else
        begin
            reps = 32'd1;
            if (pkt_left != 8'd0)
                pkt_left = pkt_left - 8'd1;
        end
        if (reps > image_left)
            reps = image_left;
        image_left = image_left - reps;
        if (cfg_rle && pkt_left == 8'd0)
            hdr_pending = 1'b1;

        pix.pixel_value   = word;
        pix.repeat_count  = reps[7:0];
        pix.last_of_image = (image_left == 32'd0);
        if (image_left == 32'd0)
            begin_image();
        return 1'b1;
    endfunction

    // Offers one byte, with random idle cycles ahead of it, and waits until
    // the decoder takes it. The stall is looked at on the falling edge, when
    // it has settled for the coming rising edge.
    task automatic send_byte(input logic [7:0] value);
        bit      taken;
        result_t pix;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= value;
        do
        begin
            @(negedge clk);
            taken = !byte_stall;
            @(posedge clk);
        end
        while (!taken);
        if (decode_byte(value, pix))
            expected_pixels.push_back(pix);
        bytes_sent++;
    endtask

    // Registers change only while the decoder is idle: no request offered, no
    // pixel owed, and a drain margin for any trailing byte.
    task automatic write_reg(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
        byte_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_register(index, value);
        reg_writes++;
    endtask

    // After reset: four bytes per pixel, run-length packets, a one pixel image.
    // A run header asking for 128 pixels is trimmed to the single pixel.
    task automatic test_reset_state();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
    endtask

    // Depth codes outside 1..4 and a zero width, in uncompressed mode.
    task automatic test_depth_and_dims();
        write_reg(REG_BYTES_PER_PIXEL, 16'd0);
        write_reg(REG_RLE_MODE, 16'd0);
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        write_reg(REG_BYTES_PER_PIXEL, 16'd7);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
    endtask

    // Three-byte pixels in a 3x1 image: a run of two, then a raw packet of six
    // trimmed to the one pixel left. The surplus bytes start the next image,
    // the first of them being taken as its packet header.
    task automatic test_run_clamp();
        write_reg(REG_BYTES_PER_PIXEL, 16'd3);
        write_reg(REG_RLE_MODE, 16'd1);
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        send_byte(8'h81);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h05);
        send_byte(8'hC4);
        send_byte(8'h3B);
        send_byte(8'h96);
        send_byte(8'h85);
        send_byte(8'h69);
    endtask

    // Largest image dimensions with two-byte pixels.
    task automatic test_extremes();
        write_reg(REG_BYTES_PER_PIXEL, 16'd2);
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    // Mostly small images, now and then a zero, the largest or a random dimension.
    function automatic logic [15:0] pick_dim();
        case ($urandom_range(19))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic randomize_config();
        logic [CFG_DATA_W-1:0] value;
        bit                    wrote;
        wrote = 1'b0;
        if ($urandom_range(1))
        begin
            value = 16'($urandom_range(0, 7));
            // Bits above the field should be ignored.
            if ($urandom_range(3) == 0)
                value = value | (16'($urandom) & 16'hFFF8);
            write_reg(REG_BYTES_PER_PIXEL, value);
            wrote = 1'b1;
        end
        if ($urandom_range(1))
        begin
            value = ($urandom_range(3) != 0) ? 16'd1 : 16'd0;
            if ($urandom_range(3) == 0)
                value = value | (16'($urandom) & 16'hFFFE);
            write_reg(REG_RLE_MODE, value);
            wrote = 1'b1;
        end
        if ($urandom_range(1))
        begin
            write_reg(REG_IMAGE_HEIGHT, pick_dim());
            wrote = 1'b1;
        end
        if ($urandom_range(1) || !wrote)
            write_reg(REG_IMAGE_WIDTH, pick_dim());
    endtask

    // Sends a well-formed image with random pixel data, cut short on large
    // images. Now and then a raw packet runs past the end of the image, which
    // throws the following image out of step.
    task automatic send_image();
        logic [31:0] left;
        int unsigned spent;
        int unsigned cnt;
        int unsigned npix;
        bit          run;
        left  = image_size();
        spent = 0;
        while (left != 0 && spent < IMAGE_BYTE_CAP)
        begin
            npix = 1;
            if (cfg_rle)
            begin
                run = $urandom_range(1);
                cnt = ($urandom_range(3) == 0) ? $urandom_range(1, 128)
                                               : $urandom_range(1, 4);
                send_byte({run, 7'(cnt - 1)});
                spent++;
                if (run)
                    left = (cnt > left) ? 32'd0 : left - cnt;
                else if (cnt > left && $urandom_range(3) != 0)
                begin
                    npix = left;
                    left = 0;
                end
                else
                begin
                    npix = cnt;
                    left = (cnt > left) ? 32'd0 : left - cnt;
                end
            end
            else
                left = left - 32'd1;
            repeat (npix * eff_bpp())
            begin
                send_byte(8'($urandom_range(0, 255)));
                spent++;
            end
        end
    endtask

    task automatic test_random_images(input int unsigned goal);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < goal)
        begin
            randomize_config();
            repeat ($urandom_range(1, 3))
            begin
                // An occasional burst of plain noise instead of an image.
                if ($urandom_range(7) == 0)
                    repeat ($urandom_range(1, 24))
                        send_byte(8'($urandom_range(0, 255)));
                else
                    send_image();
            end
        end
    endtask

    // The pixel sink decides each cycle whether to stall.
    always @(posedge clk)
    begin
        pixel_stall <= ($urandom_range(99) < stall_pct);
    end

    // Each pixel is checked on the falling edge before the rising edge that
    // takes it; nothing that the testbench drives changes in between.
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            pixels_seen++;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel: pixel_value %08h repeat_count %0d last_of_image %0b",
                       pixel_value, repeat_count, last_of_image);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_value !== want.pixel_value)
                begin
                    $error("pixel_value: expected %08h, got %08h",
                           want.pixel_value, pixel_value);
                    error_count++;
                end
                if (repeat_count !== want.repeat_count)
                begin
                    $error("repeat_count: expected %0d, got %0d",
                           want.repeat_count, repeat_count);
                    error_count++;
                end
                if (last_of_image !== want.last_of_image)
                begin
                    $error("last_of_image: expected %0b, got %0b",
                           want.last_of_image, last_of_image);
                    error_count++;
                end
            end
        end
    end

    // Ends a hung run: too many cycles in a row in which neither channel
    // completes a request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (pixel_valid && !pixel_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tga_rle_pixel_decoder_core: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_bpp    = 3'd4;
        cfg_rle    = 1'b1;
        cfg_width  = 16'd1;
        cfg_height = 16'd1;
        begin_image();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks run with a slow source and a busy sink.
        sender_idle_pct = 31;
        stall_pct       = 87;
        test_reset_state();
        test_depth_and_dims();
        test_run_clamp();
        test_extremes();

        // Random images under three handshake patterns.
        test_random_images(PHASE_BYTES);
        sender_idle_pct = 87;
        stall_pct       = 31;
        test_random_images(PHASE_BYTES);
        sender_idle_pct = 0;
        stall_pct       = 0;
        test_random_images(PHASE_BYTES);

        byte_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d bytes into %0d checked pixels over %0d register writes,",
                 bytes_sent, pixels_seen, reg_writes);
        $display("with depths 1 to 4, both packet modes and image sizes up to 65535x65535.");
        if (error_count == 0)
            $display("tga_rle_pixel_decoder_core: match");
        else
            $display("tga_rle_pixel_decoder_core: mismatch");
        $finish;
    end

endmodule
